// ----- rtl/ibe_pkg.sv -----
// ============================================================================
// ibe_pkg - shared types and constants of the I2C master bit engine
// Phase and request codes, engine state record, per-tick result record.
// ============================================================================
package ibe_pkg;

    // Timing register reset values
    localparam logic [7:0] SCL_HIGH_RESET = 8'd10;
    localparam logic [7:0] PHASE_RESET    = 8'd1;

    // Bits in one data byte
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

    // Configuration register indexes
    typedef enum logic {
        CFG_SCL_HIGH = 1'b0,
        CFG_PHASE    = 1'b1
    } t_cfg_idx;

    // Request codes carried by each tick
    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_WRITE = 3'd2,
        REQ_READ  = 3'd3,
        REQ_STOP  = 3'd4
    } t_req;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_ST_REL    = 4'd1,
        PH_ST_SDA    = 4'd2,
        PH_ST_SCL    = 4'd3,
        PH_BIT_SETUP = 4'd4,
        PH_BIT_HIGH  = 4'd5,
        PH_ACK_SETUP = 4'd6,
        PH_ACK_HIGH  = 4'd7,
        PH_TAIL_LOW  = 4'd8,
        PH_SP_SDA    = 4'd9,
        PH_SP_SCL    = 4'd10,
        PH_SP_REL    = 4'd11
    } t_phase;

    // Engine state carried from tick to tick
    typedef struct packed {
        t_phase     phase;
        logic [3:0] bit_count;
        logic [7:0] shift_reg;
        logic [7:0] tick_count;
        logic [2:0] command_latch;
        logic       ack_store;
        logic [7:0] rx_hold;
        logic       scl_drv;
        logic       sda_low;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:         PH_IDLE,
        bit_count:     4'd0,
        shift_reg:     8'd0,
        tick_count:    8'd0,
        command_latch: 3'd0,
        ack_store:     1'b0,
        rx_hold:       8'd0,
        scl_drv:       1'b1,
        sda_low:       1'b0
    };

    // Result reported for every tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic       nack_seen;
        logic [7:0] rx_byte;
    } t_result;

endpackage

// ----- rtl/i2c_master_bit_engine_top.sv -----
// ============================================================================
// i2c_master_bit_engine_top - I2C master bit engine
// Each accepted request is one timebase tick; it gives one result with the
// pin levels and status of that tick.
// ============================================================================
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  request   | i_valid / o_ready    | i_req_type, i_tx_byte, i_sda_in
//  result    | o_valid / i_ready    | o_scl_level, o_sda_pull_low, o_busy_res,
//            |                      | o_done_res, o_nack_seen, o_rx_byte
//  config    | i_cfg_we             | i_cfg_idx, i_cfg_wdata
//
//  One request per cycle while the result channel is not stalled: a request
//  register feeds the tick logic, which loads the result register and the engine state in the same cycle.
//  A stalled result holds; the request register still takes one request.
//  Synchronous active-low reset clears handshakes and engine state and loads the timing reset values.
// ============================================================================
module i2c_master_bit_engine_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_tx_byte,
    input  logic       i_sda_in,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_scl_level,
    output logic       o_sda_pull_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_nack_seen,
    output logic [7:0] o_rx_byte,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);

    logic             r_in_valid;
    logic [2:0]       r_in_req_type;
    logic [7:0]       r_in_tx_byte;
    logic             r_in_sda_in;
    logic             r_out_valid;
    ibe_pkg::t_result r_out;
    ibe_pkg::t_result n_out;
    ibe_pkg::t_state  r_state;
    ibe_pkg::t_state  n_state;
    logic [7:0]       r_scl_high_ticks;
    logic [7:0]       r_phase_ticks;
    logic             advance;

    // a tick is processed when the result register is free or being drained
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl_high_ticks <= ibe_pkg::SCL_HIGH_RESET;
            r_phase_ticks    <= ibe_pkg::PHASE_RESET;
        end else if (i_cfg_we) begin
            unique case (ibe_pkg::t_cfg_idx'(i_cfg_idx))
                ibe_pkg::CFG_SCL_HIGH: r_scl_high_ticks <= i_cfg_wdata;
                default:               r_phase_ticks    <= i_cfg_wdata;
            endcase
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_req_type <= i_req_type;
            r_in_tx_byte  <= i_tx_byte;
            r_in_sda_in   <= i_sda_in;
        end
    end

    // tick logic
    ibe_step u_step (
        .i_state          (r_state),
        .i_req_type       (r_in_req_type),
        .i_tx_byte        (r_in_tx_byte),
        .i_sda_in         (r_in_sda_in),
        .i_scl_high_ticks (r_scl_high_ticks),
        .i_phase_ticks    (r_phase_ticks),
        .o_state          (n_state),
        .o_result         (n_out)
    );

    // engine state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ibe_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_scl_level    = r_out.scl_level;
    assign o_sda_pull_low = r_out.sda_pull_low;
    assign o_busy_res     = r_out.busy_res;
    assign o_done_res     = r_out.done_res;
    assign o_nack_seen    = r_out.nack_seen;
    assign o_rx_byte      = r_out.rx_byte;

    // completion is only ever reported on a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> r_out.busy_res)
        else $error("done reported on a non-busy tick");

    // a busy tick that did not complete leaves the engine in a command phase
    a_busy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.busy_res && !r_out.done_res |-> r_state.phase != ibe_pkg::PH_IDLE)
        else $error("engine idle after an unfinished busy tick");

    // bit counter never runs past one byte
    a_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bit_count <= ibe_pkg::BITS_PER_BYTE)
        else $error("bit counter out of range");

    // engine state moves only when a result is produced
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(advance) && $past(i_rst_n) |-> $stable(r_state))
        else $error("engine state changed without a processed tick");

endmodule

// ----- rtl/ibe_step.sv -----
// ============================================================================
// ibe_step - one tick of the I2C bit sequencer
// Takes the current engine state and one tick request, gives the next state
// and the pin levels and status for that tick. Purely combinational.
// ============================================================================
module ibe_step (
    input  ibe_pkg::t_state  i_state,
    input  logic [2:0]       i_req_type,
    input  logic [7:0]       i_tx_byte,
    input  logic             i_sda_in,
    input  logic [7:0]       i_scl_high_ticks,
    input  logic [7:0]       i_phase_ticks,
    output ibe_pkg::t_state  o_state,
    output ibe_pkg::t_result o_result
);

    ibe_pkg::t_state st;
    logic            busy;
    logic            done;
    logic            wr;
    logic            is_high;
    logic            is_cmd;
    logic [7:0]      len_raw;
    logic [7:0]      len;

    always_comb begin
        st      = i_state;
        busy    = 1'b0;
        done    = 1'b0;
        is_high = 1'b0;
        len_raw = 8'd0;
        len     = 8'd1;

        // unknown phase codes fall back to idle
        if (st.phase > ibe_pkg::PH_SP_REL) begin
            st.phase = ibe_pkg::PH_IDLE;
        end

        // command launch while idle
        is_cmd = (i_req_type == ibe_pkg::REQ_START) || (i_req_type == ibe_pkg::REQ_WRITE) ||
                 (i_req_type == ibe_pkg::REQ_READ)  || (i_req_type == ibe_pkg::REQ_STOP);
        if ((st.phase == ibe_pkg::PH_IDLE) && is_cmd) begin
            st.command_latch = i_req_type;
            st.tick_count    = 8'd0;
            st.bit_count     = 4'd0;
            unique case (i_req_type)
                ibe_pkg::REQ_START: begin
                    st.phase = ibe_pkg::PH_ST_REL;
                end
                ibe_pkg::REQ_WRITE: begin
                    st.shift_reg = i_tx_byte;
                    st.phase     = ibe_pkg::PH_BIT_SETUP;
                end
                ibe_pkg::REQ_READ: begin
                    st.shift_reg = 8'd0;
                    st.phase     = ibe_pkg::PH_BIT_SETUP;
                end
                default: begin
                    st.phase = ibe_pkg::PH_SP_SDA;
                end
            endcase
        end

        wr = (st.command_latch == ibe_pkg::REQ_WRITE);

        if (st.phase != ibe_pkg::PH_IDLE) begin
            busy = 1'b1;

            // pin levels for the current phase
            unique case (st.phase)
                ibe_pkg::PH_ST_REL: begin
                    st.scl_drv = 1'b1;
                    st.sda_low = 1'b0;
                end
                ibe_pkg::PH_ST_SDA:    st.sda_low = 1'b1;
                ibe_pkg::PH_ST_SCL:    st.scl_drv = 1'b0;
                ibe_pkg::PH_BIT_SETUP: begin
                    st.scl_drv = 1'b0;
                    st.sda_low = wr ? ~st.shift_reg[7] : 1'b0;
                end
                ibe_pkg::PH_BIT_HIGH:  st.scl_drv = 1'b1;
                ibe_pkg::PH_ACK_SETUP: begin
                    st.scl_drv = 1'b0;
                    st.sda_low = ~wr;
                end
                ibe_pkg::PH_ACK_HIGH:  st.scl_drv = 1'b1;
                ibe_pkg::PH_TAIL_LOW: begin
                    st.scl_drv = 1'b0;
                    st.sda_low = 1'b0;
                end
                ibe_pkg::PH_SP_SDA: begin
                    st.scl_drv = 1'b0;
                    st.sda_low = 1'b1;
                end
                ibe_pkg::PH_SP_SCL:    st.scl_drv = 1'b1;
                default:               st.sda_low = 1'b0;
            endcase

            // phase length, zero acts as one
            is_high = (st.phase == ibe_pkg::PH_BIT_HIGH) || (st.phase == ibe_pkg::PH_ACK_HIGH) ||
                      (st.phase == ibe_pkg::PH_SP_SCL);
            len_raw = is_high ? i_scl_high_ticks : i_phase_ticks;
            len     = (len_raw == 8'd0) ? 8'd1 : len_raw;

            st.tick_count = st.tick_count + 8'd1;

            // end of phase: sample and advance
            if (st.tick_count >= len) begin
                st.tick_count = 8'd0;
                unique case (st.phase)
                    ibe_pkg::PH_ST_REL:    st.phase = ibe_pkg::PH_ST_SDA;
                    ibe_pkg::PH_ST_SDA:    st.phase = ibe_pkg::PH_ST_SCL;
                    ibe_pkg::PH_BIT_SETUP: st.phase = ibe_pkg::PH_BIT_HIGH;
                    ibe_pkg::PH_BIT_HIGH: begin
                        st.shift_reg = {st.shift_reg[6:0], (wr ? 1'b0 : i_sda_in)};
                        st.bit_count = st.bit_count + 4'd1;
                        st.phase     = (st.bit_count >= ibe_pkg::BITS_PER_BYTE) ?
                                       ibe_pkg::PH_ACK_SETUP : ibe_pkg::PH_BIT_SETUP;
                    end
                    ibe_pkg::PH_ACK_SETUP: st.phase = ibe_pkg::PH_ACK_HIGH;
                    ibe_pkg::PH_ACK_HIGH: begin
                        if (wr) begin
                            st.ack_store = i_sda_in;
                        end else begin
                            st.rx_hold = st.shift_reg;
                        end
                        st.phase = ibe_pkg::PH_TAIL_LOW;
                    end
                    ibe_pkg::PH_SP_SDA:    st.phase = ibe_pkg::PH_SP_SCL;
                    ibe_pkg::PH_SP_SCL:    st.phase = ibe_pkg::PH_SP_REL;
                    default: begin
                        // start, tail and stop end here
                        st.phase = ibe_pkg::PH_IDLE;
                        done     = 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_state                = st;
    assign o_result.scl_level     = st.scl_drv;
    assign o_result.sda_pull_low  = st.sda_low;
    assign o_result.busy_res      = busy;
    assign o_result.done_res      = done;
    assign o_result.nack_seen     = st.ack_store;
    assign o_result.rx_byte       = st.rx_hold;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench - I2C master bit engine, tick-by-tick check
// Feeds timebase ticks that carry bus commands (start, write, read, stop),
// predicts the pin levels and status of every tick, and compares each result
// with the prediction. It runs a directed set at reset timing, then directed and random bus
// transactions over several timing settings, with random gaps and stalls and
// long receiver hold-offs.
// ============================================================================
module testbench;

    // Fill modes for SDA while a command runs
    localparam int SDA_ZERO = 0;
    localparam int SDA_ONE  = 1;
    localparam int SDA_RAND = 2;

    // Long receiver hold-off, in cycles
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0] req;
        logic [7:0] tx;
        logic       sda;
        logic       paced;
    } t_tick_req;

    typedef struct packed {
        logic       scl;
        logic       sda_low;
        logic       busy;
        logic       done;
        logic       nack;
        logic [7:0] rx;
    } t_pin_status;

    typedef struct packed {
        t_pin_status res;
        logic        paced;
    } t_tick_exp;

    typedef struct {
        ibe_pkg::t_phase phase;
        logic [3:0]      bits;
        logic [7:0]      shifter;
        logic [7:0]      ticks;
        logic [2:0]      cmd;
        logic            ack;
        logic [7:0]      rx;
        logic            scl;
        logic            sda_low;
    } t_bus_state;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    logic [2:0] i_req_type  = ibe_pkg::REQ_TICK;
    logic [7:0] i_tx_byte   = 8'h00;
    logic       i_sda_in    = 1'b1;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    logic       o_scl_level;
    logic       o_sda_pull_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_nack_seen;
    logic [7:0] o_rx_byte;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_idx   = ibe_pkg::CFG_SCL_HIGH;
    logic [7:0] i_cfg_wdata = 8'h00;

    // Timing registers as the predictor sees them
    logic [7:0] cfg_scl_high = ibe_pkg::SCL_HIGH_RESET;
    logic [7:0] cfg_phase_len = ibe_pkg::PHASE_RESET;

    t_tick_req   tick_req_q[$];
    t_tick_exp   tick_exp_q[$];
    t_bus_state  plan_st;
    t_bus_state  chk_st;
    logic        plan_paced = 1'b1;

    t_tick_req   drv_item;
    t_tick_exp   drv_exp;
    t_tick_exp   mon_exp;
    bit          drv_take;
    int unsigned drv_gap;
    int unsigned mon_wait;
    int unsigned hold_left;
    int unsigned holds_asked = 0;
    int unsigned holds_done = 0;

    int unsigned n_planned = 0;
    int unsigned n_checked = 0;
    int unsigned n_cmds = 0;
    int unsigned n_done = 0;
    int unsigned n_settings = 0;
    int unsigned fail_count = 0;

    i2c_master_bit_engine_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_tx_byte      (i_tx_byte),
        .i_sda_in       (i_sda_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_scl_level    (o_scl_level),
        .o_sda_pull_low (o_sda_pull_low),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_nack_seen    (o_nack_seen),
        .o_rx_byte      (o_rx_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bus engine prediction
    // ------------------------------------------------------------------
    function automatic t_bus_state bus_reset_state();
        t_bus_state s;
        s.phase   = ibe_pkg::PH_IDLE;
        s.bits    = '0;
        s.shifter = '0;
        s.ticks   = '0;
        s.cmd     = '0;
        s.ack     = 1'b0;
        s.rx      = '0;
        s.scl     = 1'b1;
        s.sda_low = 1'b0;
        return s;
    endfunction

    // SCL-high phases use the high time, all others the phase time; 0 acts as 1
    function automatic int unsigned phase_len(input ibe_pkg::t_phase ph);
        logic [7:0] v;
        if (ph == ibe_pkg::PH_BIT_HIGH || ph == ibe_pkg::PH_ACK_HIGH ||
            ph == ibe_pkg::PH_SP_SCL)
            v = cfg_scl_high;
        else
            v = cfg_phase_len;
        return (v == 8'd0) ? 1 : int'(v);
    endfunction

    // One timebase tick: accept a command when idle, drive pins, advance phase
    function automatic t_pin_status bus_tick(inout t_bus_state s, input t_tick_req r);
        t_pin_status o;
        logic        wr;
        o = '0;
        if (s.phase == ibe_pkg::PH_IDLE && r.req >= ibe_pkg::REQ_START &&
            r.req <= ibe_pkg::REQ_STOP) begin
            s.cmd   = r.req;
            s.ticks = '0;
            s.bits  = '0;
            case (r.req)
                ibe_pkg::REQ_START: s.phase = ibe_pkg::PH_ST_REL;
                ibe_pkg::REQ_WRITE: begin
                    s.shifter = r.tx;
                    s.phase   = ibe_pkg::PH_BIT_SETUP;
                end
                ibe_pkg::REQ_READ: begin
                    s.shifter = '0;
                    s.phase   = ibe_pkg::PH_BIT_SETUP;
                end
                default: s.phase = ibe_pkg::PH_SP_SDA;
            endcase
        end
        wr = (s.cmd == ibe_pkg::REQ_WRITE);

        if (s.phase != ibe_pkg::PH_IDLE) begin
            o.busy = 1'b1;
            // pin levels for this phase
            case (s.phase)
                ibe_pkg::PH_ST_REL: begin
                    s.scl     = 1'b1;
                    s.sda_low = 1'b0;
                end
                ibe_pkg::PH_ST_SDA: s.sda_low = 1'b1;
                ibe_pkg::PH_ST_SCL: s.scl = 1'b0;
                ibe_pkg::PH_BIT_SETUP: begin
                    s.scl     = 1'b0;
                    s.sda_low = wr ? ~s.shifter[7] : 1'b0;
                end
                ibe_pkg::PH_BIT_HIGH, ibe_pkg::PH_ACK_HIGH, ibe_pkg::PH_SP_SCL: s.scl = 1'b1;
                ibe_pkg::PH_ACK_SETUP: begin
                    s.scl     = 1'b0;
                    s.sda_low = ~wr;
                end
                ibe_pkg::PH_TAIL_LOW: begin
                    s.scl     = 1'b0;
                    s.sda_low = 1'b0;
                end
                ibe_pkg::PH_SP_SDA: begin
                    s.scl     = 1'b0;
                    s.sda_low = 1'b1;
                end
                default: s.sda_low = 1'b0;
            endcase

            // phase timing; samples land on the last tick of SCL high
            s.ticks = s.ticks + 8'd1;
            if (s.ticks >= phase_len(s.phase)) begin
                s.ticks = '0;
                case (s.phase)
                    ibe_pkg::PH_ST_REL:    s.phase = ibe_pkg::PH_ST_SDA;
                    ibe_pkg::PH_ST_SDA:    s.phase = ibe_pkg::PH_ST_SCL;
                    ibe_pkg::PH_BIT_SETUP: s.phase = ibe_pkg::PH_BIT_HIGH;
                    ibe_pkg::PH_BIT_HIGH: begin
                        s.shifter = {s.shifter[6:0], wr ? 1'b0 : r.sda};
                        s.bits    = s.bits + 4'd1;
                        if (s.bits >= ibe_pkg::BITS_PER_BYTE)
                            s.phase = ibe_pkg::PH_ACK_SETUP;
                        else
                            s.phase = ibe_pkg::PH_BIT_SETUP;
                    end
                    ibe_pkg::PH_ACK_SETUP: s.phase = ibe_pkg::PH_ACK_HIGH;
                    ibe_pkg::PH_ACK_HIGH: begin
                        if (wr)
                            s.ack = r.sda;
                        else
                            s.rx = s.shifter;
                        s.phase = ibe_pkg::PH_TAIL_LOW;
                    end
                    ibe_pkg::PH_SP_SDA: s.phase = ibe_pkg::PH_SP_SCL;
                    ibe_pkg::PH_SP_SCL: s.phase = ibe_pkg::PH_SP_REL;
                    default: begin
                        s.phase = ibe_pkg::PH_IDLE;
                        o.done  = 1'b1;
                    end
                endcase
            end
        end

        o.scl     = s.scl;
        o.sda_low = s.sda_low;
        o.nack    = s.ack;
        o.rx      = s.rx;
        return o;
    endfunction

    // Per-request wait: none when unpaced; when paced, none for half, else drawn at random
    function automatic int unsigned pick_gap(input logic paced);
        if (!paced || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // Random request code beyond the defined set
    function automatic logic [2:0] stray_req();
        return 3'($urandom_range(int'(ibe_pkg::REQ_STOP) + 1, 7));
    endfunction

    task automatic flag_miss(input string what, input int unsigned want, input int unsigned got);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH tick %0d %s: expected %0h, got %0h", n_checked, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            drv_take = i_valid && o_ready;
            if (drv_take) begin
                drv_exp.res   = bus_tick(chk_st, drv_item);
                drv_exp.paced = drv_item.paced;
                tick_exp_q.push_back(drv_exp);
                drv_gap = pick_gap(drv_item.paced);
            end
            if (!i_valid || drv_take) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_valid <= 1'b0;
                end else if (tick_req_q.size() > 0) begin
                    drv_item = tick_req_q.pop_front();
                    i_valid    <= 1'b1;
                    i_req_type <= drv_item.req;
                    i_tx_byte  <= drv_item.tx;
                    i_sda_in   <= drv_item.sda;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off counter
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with per-result stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            mon_wait = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (tick_exp_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("MISMATCH result with no request pending");
                end else begin
                    mon_exp = tick_exp_q.pop_front();
                    if (o_scl_level !== mon_exp.res.scl)
                        flag_miss("scl_level", mon_exp.res.scl, o_scl_level);
                    if (o_sda_pull_low !== mon_exp.res.sda_low)
                        flag_miss("sda_pull_low", mon_exp.res.sda_low, o_sda_pull_low);
                    if (o_busy_res !== mon_exp.res.busy)
                        flag_miss("busy_res", mon_exp.res.busy, o_busy_res);
                    if (o_done_res !== mon_exp.res.done)
                        flag_miss("done_res", mon_exp.res.done, o_done_res);
                    if (o_nack_seen !== mon_exp.res.nack)
                        flag_miss("nack_seen", mon_exp.res.nack, o_nack_seen);
                    if (o_rx_byte !== mon_exp.res.rx)
                        flag_miss("rx_byte", mon_exp.res.rx, o_rx_byte);
                    if (mon_exp.res.done)
                        n_done++;
                    n_checked++;
                    mon_wait = pick_gap(mon_exp.paced);
                end
            end else if (mon_wait > 0) begin
                mon_wait--;
            end
            i_ready <= (mon_wait == 0 && hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------
    // Queue one tick and advance the planning copy of the engine
    task automatic push_tick(input logic [2:0] req, input logic [7:0] tx, input logic sda);
        t_tick_req it;
        it = '{req: req, tx: tx, sda: sda, paced: plan_paced};
        if (plan_st.phase == ibe_pkg::PH_IDLE && req >= ibe_pkg::REQ_START &&
            req <= ibe_pkg::REQ_STOP)
            n_cmds++;
        void'(bus_tick(plan_st, it));
        tick_req_q.push_back(it);
        n_planned++;
    endtask

    // Ticks until the engine is idle; some carry commands that must be ignored
    task automatic finish_cmd(input int sda_mode);
        logic [2:0] rq;
        logic       sd;
        while (plan_st.phase != ibe_pkg::PH_IDLE) begin
            rq = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(1, 7)) : ibe_pkg::REQ_TICK;
            case (sda_mode)
                SDA_ZERO: sd = 1'b0;
                SDA_ONE:  sd = 1'b1;
                default:  sd = 1'($urandom_range(0, 1));
            endcase
            push_tick(rq, 8'($urandom), sd);
        end
    endtask

    task automatic bus_cmd(input ibe_pkg::t_req rq, input logic [7:0] tx, input int sda_mode);
        push_tick(rq, tx, 1'($urandom_range(0, 1)));
        finish_cmd(sda_mode);
    endtask

    // Mostly well-formed transactions, with stray codes and lone commands
    task automatic random_transaction();
        logic [7:0] addr;
        int         nbytes;
        plan_paced = ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(0, 4))
            push_tick($urandom_range(0, 1) ? ibe_pkg::REQ_TICK : stray_req(), 8'($urandom),
                      1'($urandom_range(0, 1)));
        if ($urandom_range(0, 6) == 0) begin
            bus_cmd(ibe_pkg::t_req'($urandom_range(ibe_pkg::REQ_START, ibe_pkg::REQ_STOP)),
                    8'($urandom), SDA_RAND);
        end else begin
            addr = 8'($urandom);
            bus_cmd(ibe_pkg::REQ_START, 8'($urandom), SDA_RAND);
            bus_cmd(ibe_pkg::REQ_WRITE, addr, SDA_RAND);
            nbytes = $urandom_range(1, 4);
            for (int b = 0; b < nbytes; b++) begin
                if (b > 0 && $urandom_range(0, 9) == 0)
                    bus_cmd(ibe_pkg::REQ_START, 8'($urandom), SDA_RAND);
                if (addr[0])
                    bus_cmd(ibe_pkg::REQ_READ, 8'($urandom), SDA_RAND);
                else
                    bus_cmd(ibe_pkg::REQ_WRITE, 8'($urandom), SDA_RAND);
            end
            if ($urandom_range(0, 6) != 0)
                bus_cmd(ibe_pkg::REQ_STOP, 8'($urandom), SDA_RAND);
        end
    endtask

    task automatic wait_drained();
        while (n_checked != n_planned)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both timing registers; only called with the engine drained
    task automatic set_timing(input logic [7:0] high_t, input logic [7:0] phase_t);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= ibe_pkg::CFG_SCL_HIGH;
        i_cfg_wdata <= high_t;
        @(posedge i_clk);
        i_cfg_idx   <= ibe_pkg::CFG_PHASE;
        i_cfg_wdata <= phase_t;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_scl_high  = high_t;
        cfg_phase_len = phase_t;
        n_settings++;
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned first;
        first = n_planned;
        while (n_planned - first < budget)
            random_transaction();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        plan_st = bus_reset_state();
        chk_st  = bus_reset_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed set at reset timing
        n_settings = 1;
        push_tick(ibe_pkg::REQ_TICK, 8'hFF, 1'b1);
        push_tick(ibe_pkg::REQ_TICK, 8'h00, 1'b0);
        for (int c = int'(ibe_pkg::REQ_STOP) + 1; c < 8; c++)
            push_tick(3'(c), 8'($urandom), 1'($urandom_range(0, 1)));
        bus_cmd(ibe_pkg::REQ_STOP, 8'h00, SDA_RAND);          // stop with no start
        bus_cmd(ibe_pkg::REQ_START, 8'h00, SDA_RAND);
        push_tick(ibe_pkg::REQ_WRITE, 8'hA5, 1'b0);
        push_tick(ibe_pkg::REQ_STOP, 8'h00, 1'b0);            // ignored while busy
        finish_cmd(SDA_ZERO);
        bus_cmd(ibe_pkg::REQ_STOP, 8'($urandom), SDA_RAND);
        push_tick(ibe_pkg::REQ_TICK, 8'($urandom), 1'b1);
        wait_drained();

        // fastest timing: data patterns, repeated start and reads
        set_timing(8'd1, 8'd1);
        bus_cmd(ibe_pkg::REQ_WRITE, 8'hFF, SDA_ONE);          // all ones, NACK
        bus_cmd(ibe_pkg::REQ_WRITE, 8'h00, SDA_ZERO);         // all zeros, ACK
        bus_cmd(ibe_pkg::REQ_START, 8'hFF, SDA_RAND);         // repeated start
        bus_cmd(ibe_pkg::REQ_READ, 8'h00, SDA_ONE);
        bus_cmd(ibe_pkg::REQ_READ, 8'hFF, SDA_ZERO);
        bus_cmd(ibe_pkg::REQ_READ, 8'($urandom), SDA_RAND);
        bus_cmd(ibe_pkg::REQ_STOP, 8'($urandom), SDA_RAND);
        bus_cmd(ibe_pkg::REQ_READ, 8'($urandom), SDA_RAND);   // read outside a transaction
        push_tick(ibe_pkg::REQ_TICK, 8'($urandom), 1'b1);

        // random traffic at fastest timing, with a long receiver hold-off
        holds_asked++;
        random_phase(80);

        // zero registers act as one; no idling here
        set_timing(8'd0, 8'd0);
        plan_paced = 1'b0;
        bus_cmd(ibe_pkg::REQ_START, 8'($urandom), SDA_RAND);
        bus_cmd(ibe_pkg::REQ_WRITE, 8'($urandom), SDA_RAND);
        bus_cmd(ibe_pkg::REQ_READ, 8'($urandom), SDA_RAND);
        bus_cmd(ibe_pkg::REQ_STOP, 8'($urandom), SDA_RAND);
        wait_drained();

        // longest SCL high time
        set_timing(8'd255, 8'd1);
        bus_cmd(ibe_pkg::REQ_STOP, 8'($urandom), SDA_RAND);
        wait_drained();

        // a couple of random short settings
        for (int k = 0; k < 2; k++) begin
            set_timing(8'($urandom_range(1, 2)), 8'($urandom_range(1, 2)));
            if (k == 1)
                holds_asked++;
            random_phase(40);
        end

        repeat (10) @(posedge i_clk);
        if (tick_exp_q.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", tick_exp_q.size());
        end
        $display("Checked %0d ticks over %0d timing settings: %0d bus commands, %0d completions,",
                 n_checked, n_settings, n_cmds, n_done);
        $display("%0d long result hold-offs, %0d mismatches", holds_done, fail_count);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ibe_pkg.sv
rtl/ibe_step.sv
rtl/i2c_master_bit_engine_top.sv
verif/testbench.sv
